### design/ppw_pkg.sv
`timescale 1ns / 1ps

package ppw_pkg;

  localparam int SET_W    = 16;
  localparam int SET_FRAC = 12;
  localparam int GAIN     = 10;
  localparam int CFG_AW   = 2;

  localparam logic [SET_W-1:0] DIST_RESET  = 16'd4096;
  localparam logic [SET_W-1:0] VCOMP_RESET = 16'd0;

  typedef enum logic [CFG_AW-1:0] {
    REG_DISTANCE = 2'd0,
    REG_VCOMP    = 2'd1
  } cfg_reg_t;

  function automatic int ppw_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/ppw_if.sv
`timescale 1ns / 1ps

interface ppw_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] in_x;
  logic [W-1:0] in_y;
  logic [W-1:0] in_z;

  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface ppw_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_x;
  logic [W-1:0] out_y;
  logic [W-1:0] out_z;
  logic         clipped;

  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

### design/panini_projection_warp.sv
`timescale 1ns / 1ps

// Panini projection of a stream of points (x, y, z), signed fixed point with
// FRAC_BITS fraction bits; z passes through. clipped flags a saturated x or y.
// in_bus: valid/ready channel, a beat is taken when valid and ready are high.
// out_bus: valid/ready channel carrying out_x, out_y, out_z and clipped.
// cfg_we/cfg_addr/cfg_wdata: register 0 is distance (unsigned Q4.12),
// register 1 is vertical compression (signed Q4.12); write only while idle.
// Throughput: one point per cycle while in_bus.ready is high, no dependence
// between points. The pipeline depth comes from the one-bit-per-stage square
// root and the two one-bit-per-stage dividers. A two-entry output buffer sits
// after the pipeline; the pipeline advances while that buffer has room, so a
// new beat is taken while one result waits. When the receiver stalls long
// enough to fill the buffer, in_bus.ready drops and every stage holds. Reset
// empties the pipeline and buffer and loads distance 1.0 and compression 0.
module panini_projection_warp #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ppw_in_if.sink                      in_bus,
  ppw_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [ppw_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ppw_pkg::SET_W-1:0]   cfg_wdata
);
  import ppw_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MX   = ppw_max(F, W - 1) + 1;
  localparam int NW   = 2 * MX;
  localparam int RW   = MX + 1;
  localparam int SQL  = MX + 1;
  localparam int AW   = SET_W + 1;
  localparam int DW   = SET_W + RW + 1;
  localparam int PW   = AW + W;
  localparam int NXW  = ppw_max(PW + F + 1, DW) + 1;
  localparam int DXW  = DW + 1;
  localparam int CRW  = SET_W + RW + 1;
  localparam int KW   = CRW + 5;
  localparam int AKW  = KW - 1;
  localparam int KL   = AKW / 2;
  localparam int KH   = AKW - KL;
  localparam int PYW  = PW + AKW;
  localparam int DSW  = DW + SET_FRAC;
  localparam int NYW  = ppw_max(PYW + 1, DSW) + 1;
  localparam int DYW  = DSW + 1;
  localparam int VL   = SQL + W + 7;
  localparam int SB1W = 3 * W + 2;
  localparam int SB2W = W + 2;
  localparam int OBW  = 3 * W + 1;

  localparam logic [NW-1:0]       ONE_SQ = NW'(1) << (2 * F);
  localparam logic [AW-1:0]       ONE_S  = AW'(1) << SET_FRAC;
  localparam logic signed [RW:0]  ONE_C  = (RW + 1)'(1) << F;
  localparam logic [DW-1:0]       ONE_D  = DW'(1) << (SET_FRAC + F);
  localparam logic signed [KW-1:0] ONE_K = KW'(1) << (SET_FRAC + F);

  logic [SET_W-1:0]        dist_r;
  logic signed [SET_W-1:0] vc_r;

  logic          en;
  logic          full;
  logic [VL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RESET;
      vc_r   <= VCOMP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DISTANCE: dist_r <= cfg_wdata;
        REG_VCOMP:    vc_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en           = !full;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VL-2:0], in_bus.valid};
    end
  end

  // capture
  logic [W-1:0] x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_bus.in_x;
      y0_r <= in_bus.in_y;
      z0_r <= in_bus.in_z;
    end
  end

  // magnitudes and 1 + x^2
  logic [W-1:0]  ax0, ay0;
  logic [NW-1:0] n1_r;
  logic [W-1:0]  ax1_r, ay1_r, z1_r;
  logic          sx1_r, sy1_r;

  assign ax0 = x0_r[W-1] ? (~x0_r + W'(1)) : x0_r;
  assign ay0 = y0_r[W-1] ? (~y0_r + W'(1)) : y0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= NW'(ax0) * NW'(ax0) + ONE_SQ;
      ax1_r <= ax0;
      ay1_r <= ay0;
      sx1_r <= x0_r[W-1];
      sy1_r <= y0_r[W-1];
      z1_r  <= z0_r;
    end
  end

  logic [RW-1:0] r;

  ppw_isqrt #(.NW(NW)) u_isqrt (
    .clk (clk),
    .en  (en),
    .n   (n1_r),
    .r   (r)
  );

  logic [SB1W-1:0] sb1_r [SQL];

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= {ax1_r, ay1_r, sx1_r, sy1_r, z1_r};
      for (int i = 1; i < SQL; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  logic [W-1:0] ax2, ay2, z2;
  logic         sx2, sy2;

  assign {ax2, ay2, sx2, sy2, z2} = sb1_r[SQL-1];

  // scale terms
  logic [AW-1:0]          a2;
  logic signed [RW:0]     rm1;
  logic [DW-1:0]          den3_r;
  logic [PW-1:0]          px3_r, py3_r;
  logic signed [CRW-1:0]  cr3_r;
  logic                   sx3_r, sy3_r;
  logic [W-1:0]           z3_r;

  assign a2  = AW'(dist_r) + ONE_S;
  assign rm1 = $signed({1'b0, r}) - ONE_C;

  always_ff @(posedge clk) begin
    if (en) begin
      den3_r <= DW'(dist_r) * DW'(r) + ONE_D;
      px3_r  <= PW'(a2) * PW'(ax2);
      py3_r  <= PW'(a2) * PW'(ay2);
      cr3_r  <= CRW'(vc_r) * CRW'(rm1);
      sx3_r  <= sx2;
      sy3_r  <= sy2;
      z3_r   <= z2;
    end
  end

  // compression factor, x numerator
  logic signed [KW-1:0] k4_r;
  logic [NXW-1:0]       nx4_r;
  logic [DXW-1:0]       dx4_r;
  logic [DSW-1:0]       ds4_r;
  logic [PW-1:0]        py4_r;
  logic                 sx4_r, sy4_r;
  logic [W-1:0]         z4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      k4_r  <= KW'(cr3_r) * KW'(GAIN) + ONE_K;
      nx4_r <= (NXW'(px3_r) << (F + 1)) + NXW'(den3_r);
      dx4_r <= {den3_r, 1'b0};
      ds4_r <= DSW'(den3_r) << SET_FRAC;
      py4_r <= py3_r;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      z4_r  <= z3_r;
    end
  end

  // y partial products
  logic [AKW-1:0]    ak4;
  logic [PW+KL-1:0]  pl5_r;
  logic [PW+KH-1:0]  ph5_r;
  logic [NXW-1:0]    nx5_r;
  logic [DXW-1:0]    dx5_r;
  logic [DSW-1:0]    ds5_r;
  logic              sx5_r, ny5_r;
  logic [W-1:0]      z5_r;

  assign ak4 = k4_r[KW-1] ? AKW'(-k4_r) : AKW'(k4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pl5_r <= (PW + KL)'(py4_r) * (PW + KL)'(ak4[KL-1:0]);
      ph5_r <= (PW + KH)'(py4_r) * (PW + KH)'(ak4[AKW-1:KL]);
      nx5_r <= nx4_r;
      dx5_r <= dx4_r;
      ds5_r <= ds4_r;
      sx5_r <= sx4_r;
      ny5_r <= sy4_r ^ k4_r[KW-1];
      z5_r  <= z4_r;
    end
  end

  // y numerator
  logic [PYW-1:0] py5;
  logic [NYW-1:0] ny6_r;
  logic [DYW-1:0] dy6_r;
  logic [NXW-1:0] nx6_r;
  logic [DXW-1:0] dx6_r;
  logic           sx6_r, ng6_r;
  logic [W-1:0]   z6_r;

  assign py5 = (PYW'(ph5_r) << KL) + PYW'(pl5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ny6_r <= (NYW'(py5) << 1) + NYW'(ds5_r);
      dy6_r <= {ds5_r, 1'b0};
      nx6_r <= nx5_r;
      dx6_r <= dx5_r;
      sx6_r <= sx5_r;
      ng6_r <= ny5_r;
      z6_r  <= z5_r;
    end
  end

  logic [W-1:0] qx, qy;
  logic         ovx, ovy;

  ppw_div #(.NUMW(NXW), .DENW(DXW), .QW(W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx6_r),
    .den (dx6_r),
    .q   (qx),
    .ovf (ovx)
  );

  ppw_div #(.NUMW(NYW), .DENW(DYW), .QW(W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny6_r),
    .den (dy6_r),
    .q   (qy),
    .ovf (ovy)
  );

  logic [SB2W-1:0] sb2_r [W];

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= {sx6_r, ng6_r, z6_r};
      for (int i = 1; i < W; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  logic         sx7, ng7;
  logic [W-1:0] z7;

  assign {sx7, ng7, z7} = sb2_r[W-1];

  function automatic logic [W:0] sat_f(input logic neg, input logic [W-1:0] q,
                                       input logic ovf);
    logic [W-1:0] lim;
    logic [W-1:0] m;
    logic         over;
    lim  = neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    over = ovf || (q > lim);
    m    = over ? lim : q;
    return {over, neg ? (~m + W'(1)) : m};
  endfunction

  logic [W:0]   satx, saty;
  logic [W-1:0] ox_r, oy_r, oz_r;
  logic         clip_r;

  assign satx = sat_f(sx7, qx, ovx);
  assign saty = sat_f(ng7, qy, ovy);

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r   <= satx[W-1:0];
      oy_r   <= saty[W-1:0];
      oz_r   <= z7;
      clip_r <= satx[W] | saty[W];
    end
  end

  logic [OBW-1:0] ob_dout;

  ppw_obuf #(.WIDTH(OBW)) u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (en && vld_r[VL-1]),
    .din   ({ox_r, oy_r, oz_r, clip_r}),
    .full  (full),
    .valid (out_bus.valid),
    .ready (out_bus.ready),
    .dout  (ob_dout)
  );

  assign {out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.clipped} = ob_dout;

endmodule

### design/ppw_isqrt.sv
`timescale 1ns / 1ps

module ppw_isqrt #(
  parameter int NW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  output logic [NW/2:0] r
);
  localparam int ST = NW / 2;
  localparam int RW = ST + 1;

  logic [NW-1:0] rem_r [ST];
  logic [NW-1:0] res_r [ST];
  logic [RW-1:0] r_r;

  for (genvar j = 0; j < ST; j++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * j);
    logic [NW-1:0] rem_in;
    logic [NW-1:0] res_in;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [NW-1:0] res_nxt;

    if (j == 0) begin : g_first
      assign rem_in = n;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign res_in = res_r[j-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        res_r[j] <= res_nxt;
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_r[ST-1] > res_r[ST-1]) begin
        r_r <= RW'(res_r[ST-1]) + RW'(1);
      end else begin
        r_r <= RW'(res_r[ST-1]);
      end
    end
  end

  assign r = r_r;

endmodule

### design/ppw_div.sv
`timescale 1ns / 1ps

module ppw_div #(
  parameter int NUMW = 48,
  parameter int DENW = 35,
  parameter int QW   = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            ovf
);
  import ppw_pkg::*;

  localparam int CW = ppw_max(NUMW, DENW + QW) + 1;

  logic [CW-1:0]   rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   q_r   [QW];
  logic            ov_r  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0]   rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   q_in;
    logic            ov_in;
    logic [CW-1:0]   sub;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_in = CW'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign ov_in  = CW'(num) >= (CW'(den) << QW);
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign ov_in  = ov_r[j-1];
    end

    assign sub = CW'(den_in) << (QW - 1 - j);
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? (rem_in - sub) : rem_in;
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[QW-2:0], ge};
        ov_r[j]  <= ov_in;
      end
    end
  end

  assign q   = q_r[QW-1];
  assign ovf = ov_r[QW-1];

endmodule

### design/ppw_obuf.sv
`timescale 1ns / 1ps

module ppw_obuf #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  output logic             valid,
  input  logic             ready,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] mem_r [2];
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             wp_r;
  logic             rp_r;
  logic             pop;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign pop   = valid && ready;
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### design/ppw_checker.sv
`timescale 1ns / 1ps

module ppw_checker #(
  parameter int W = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_x,
  input logic [W-1:0] out_y,
  input logic [W-1:0] out_z,
  input logic         clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_x, out_y, out_z, clipped}))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output buffer");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn while stalled");

endmodule

bind panini_projection_warp ppw_checker #(.W(COORD_WIDTH)) u_ppw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_x     (out_bus.out_x),
  .out_y     (out_bus.out_y),
  .out_z     (out_bus.out_z),
  .clipped   (out_bus.clipped)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppw_pkg::*;

  localparam int CW      = 16;
  localparam int FB      = 12;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          clip;
  } warped_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [SET_W-1:0]  cfg_wdata;

  ppw_in_if  #(.W(CW)) in_bus ();
  ppw_out_if #(.W(CW)) out_bus ();

  panini_projection_warp #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  logic [15:0]  dist_q;
  logic signed [15:0] vcomp_q;
  point_t       pending_pts[$];
  warped_t      expected_pts[$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           errors;
  int           n_sent;
  int           n_seen;
  int           n_clipped;
  longint       cycles;
  logic         in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt_near(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > res) res = res + 1;
    return res;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input logic neg, input logic [127:0] mag,
                                                ref logic clip);
    logic [127:0] lim;
    logic [127:0] m;
    lim = (128'd1 << (CW - 1)) - (neg ? 128'd0 : 128'd1);
    m   = mag;
    if (m > lim) begin
      m    = lim;
      clip = 1'b1;
    end
    return neg ? CW'(-m) : CW'(m);
  endfunction

  function automatic warped_t project_point(input point_t p);
    warped_t      w;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] cs;
    logic signed [63:0] k;
    logic [63:0]  ax;
    logic [63:0]  ay;
    logic [63:0]  ak;
    logic [63:0]  r;
    logic [127:0] den;
    logic [127:0] a;
    logic [127:0] qx;
    logic [127:0] qy;
    logic [127:0] dy;
    logic         clip;
    xs   = $signed(p.x);
    ys   = $signed(p.y);
    cs   = vcomp_q;
    ax   = xs < 0 ? -xs : xs;
    ay   = ys < 0 ? -ys : ys;
    r    = isqrt_near((64'd1 << (2 * FB)) + ax * ax);
    den  = 128'(dist_q) * r + (128'd1 << (SET_FRAC + FB));
    a    = 128'(dist_q) + (128'd1 << SET_FRAC);
    k    = GAIN * cs * $signed(r - (64'd1 << FB)) + (64'sd1 <<< (SET_FRAC + FB));
    ak   = k < 0 ? -k : k;
    qx   = (2 * (a * ax * (128'd1 << FB)) + den) / (2 * den);
    dy   = den << SET_FRAC;
    qy   = (2 * (a * ay * ak) + dy) / (2 * dy);
    clip = 1'b0;
    w.x  = clamp_coord(xs < 0, qx, clip);
    w.y  = clamp_coord((ys < 0) != (k < 0), qy, clip);
    w.z  = p.z;
    w.clip = clip;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    $display("MISMATCH %s: got %h want %h (beat %0d)", what, got, want, n_seen);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_taken) begin
      // hold
    end else if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      point_t p;
      p = pending_pts.pop_front();
      in_bus.valid <= 1'b1;
      in_bus.in_x  <= p.x;
      in_bus.in_y  <= p.y;
      in_bus.in_z  <= p.z;
    end else begin
      in_bus.valid <= 1'b0;
    end
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      expected_pts.push_back(project_point({in_bus.in_x, in_bus.in_y, in_bus.in_z}));
      n_sent++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      warped_t w;
      if (expected_pts.size() == 0) begin
        $display("Unexpected beat: %h %h %h", out_bus.out_x, out_bus.out_y, out_bus.out_z);
        errors++;
      end else begin
        w = expected_pts.pop_front();
        if (out_bus.out_x !== w.x) report_mismatch("out_x", out_bus.out_x, w.x);
        if (out_bus.out_y !== w.y) report_mismatch("out_y", out_bus.out_y, w.y);
        if (out_bus.out_z !== w.z) report_mismatch("out_z", out_bus.out_z, w.z);
        if (out_bus.clipped !== w.clip)
          report_mismatch("clipped", CW'(out_bus.clipped), CW'(w.clip));
        if (w.clip) n_clipped++;
      end
      n_seen++;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [SET_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DISTANCE) dist_q = val;
    else vcomp_q = val;
  endtask

  task automatic drain;
    while (pending_pts.size() > 0 || in_bus.valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(16384)) - 8192);
      2: return CW'($signed($urandom_range(2048)) - 1024);
      default: return $urandom_range(1) ? 16'h7fff - CW'($urandom_range(15))
                                        : 16'h8000 + CW'($urandom_range(15));
    endcase
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++)
      pending_pts.push_back({rand_coord(), rand_coord(), CW'($urandom)});
    drain();
  endtask

  logic [CW-1:0] edge_vals[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                                  16'hffff, 16'h1000, 16'hf000, 16'h5555};
  logic [SET_W-1:0] dists[5] = '{16'd0, 16'd4096, 16'hffff, 16'd1024, 16'd20000};
  logic [SET_W-1:0] comps[5] = '{16'd0, 16'h7fff, 16'h8000, 16'd200, 16'hff00};

  initial begin
    int seg;
    cycles = 0; errors = 0; n_sent = 0; n_seen = 0; n_clipped = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_bus.valid = 1'b0; in_bus.in_x = '0; in_bus.in_y = '0; in_bus.in_z = '0;
    out_bus.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    dist_q = DIST_RESET; vcomp_q = VCOMP_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // edge values under reset settings
    for (int i = 0; i < 8; i++)
      pending_pts.push_back({edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8]});
    drain();
    write_reg(REG_DISTANCE, 16'd0);
    write_reg(REG_VCOMP, 16'h8000);
    for (int i = 0; i < 8; i++)
      pending_pts.push_back({edge_vals[(i + 1) % 8], edge_vals[i], edge_vals[i]});
    drain();
    write_reg(REG_DISTANCE, 16'hffff);
    write_reg(REG_VCOMP, 16'h7fff);
    for (int i = 0; i < 8; i++)
      pending_pts.push_back({edge_vals[i], edge_vals[(i + 5) % 8], edge_vals[7 - i]});
    drain();

    seg = 0;
    for (int d = 0; d < 5; d++) begin
      write_reg(REG_DISTANCE, dists[d]);
      write_reg(REG_VCOMP, comps[(d + 2) % 5]);
      case (seg % 4)
        0: run_phase(390, 0, 0);
        1: run_phase(390, 45, 0);
        2: run_phase(390, 0, 45);
        default: run_phase(390, 21, 21);
      endcase
      seg++;
    end

    $display("Sent %0d points over 8 register settings, %0d results checked, %0d clipped",
             n_sent, n_seen, n_clipped);
    $display("Idle and stall mixes covered with extreme distance and compression values");
    if (errors == 0 && expected_pts.size() == 0)
      $display("Test completed successfully");
    else begin
      $display("%0d mismatches, %0d results missing", errors, expected_pts.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### panini_projection_warp.f
design/ppw_pkg.sv
design/ppw_if.sv
design/ppw_isqrt.sv
design/ppw_div.sv
design/ppw_obuf.sv
design/panini_projection_warp.sv
design/ppw_checker.sv
sim/tb_top.sv
